>>> rtl/mlk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlk_pkg
// types, register indexes and the character code table of the morse keyer
// ----------------------------------------------------------------------------
package mlk_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned PatW    = 6;
  localparam int unsigned LenW    = 3;
  localparam int unsigned TabIdxW = 6;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [3:0]         nib_t;

  localparam cfg_idx_t RegDotLedMask  = 3'd0;
  localparam cfg_idx_t RegDashLedMask = 3'd1;
  localparam cfg_idx_t RegDotOnUnits  = 3'd2;
  localparam cfg_idx_t RegDashOnUnits = 3'd3;
  localparam cfg_idx_t RegGapUnits    = 3'd4;

  // pattern is left-aligned: first element sent sits in the top bit, 1 = dash
  typedef struct packed {
    logic [LenW-1:0] len;
    logic [PatW-1:0] pat;
  } code_t;

  // map an ascii byte onto its place in the code table, 0 for uncoded
  function automatic logic [TabIdxW-1:0] table_index(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c > 8'd122)      t = 8'd0;
    else if (c > 8'd96)  t = c - 8'd96;
    else if (c > 8'd90)  t = 8'd0;
    else if (c > 8'd64)  t = c - 8'd64;
    else if (c == 8'd63) t = 8'd39;
    else if (c > 8'd57)  t = 8'd0;
    else if (c > 8'd47)  t = c - 8'd21;
    else if (c == 8'd46) t = 8'd38;
    else if (c == 8'd44) t = 8'd37;
    else                 t = 8'd0;
    return t[TabIdxW-1:0];
  endfunction

  function automatic code_t code_lookup(input logic [TabIdxW-1:0] idx);
    code_t r;
    case (idx)
      6'd1:  r = '{3'd2, 6'b010000};  // a
      6'd2:  r = '{3'd4, 6'b100000};  // b
      6'd3:  r = '{3'd4, 6'b101000};  // c
      6'd4:  r = '{3'd3, 6'b100000};  // d
      6'd5:  r = '{3'd1, 6'b000000};  // e
      6'd6:  r = '{3'd4, 6'b001000};  // f
      6'd7:  r = '{3'd3, 6'b110000};  // g
      6'd8:  r = '{3'd4, 6'b000000};  // h
      6'd9:  r = '{3'd2, 6'b000000};  // i
      6'd10: r = '{3'd4, 6'b011100};  // j
      6'd11: r = '{3'd3, 6'b101000};  // k
      6'd12: r = '{3'd4, 6'b010000};  // l
      6'd13: r = '{3'd2, 6'b110000};  // m
      6'd14: r = '{3'd2, 6'b100000};  // n
      6'd15: r = '{3'd3, 6'b111000};  // o
      6'd16: r = '{3'd4, 6'b011000};  // p
      6'd17: r = '{3'd4, 6'b110100};  // q
      6'd18: r = '{3'd3, 6'b010000};  // r
      6'd19: r = '{3'd3, 6'b000000};  // s
      6'd20: r = '{3'd1, 6'b100000};  // t
      6'd21: r = '{3'd3, 6'b001000};  // u
      6'd22: r = '{3'd4, 6'b000100};  // v
      6'd23: r = '{3'd3, 6'b011000};  // w
      6'd24: r = '{3'd4, 6'b100100};  // x
      6'd25: r = '{3'd4, 6'b101100};  // y
      6'd26: r = '{3'd4, 6'b110000};  // z
      6'd27: r = '{3'd5, 6'b111110};  // 0
      6'd28: r = '{3'd5, 6'b011110};  // 1
      6'd29: r = '{3'd5, 6'b001110};  // 2
      6'd30: r = '{3'd5, 6'b000110};  // 3
      6'd31: r = '{3'd5, 6'b000010};  // 4
      6'd32: r = '{3'd5, 6'b000000};  // 5
      6'd33: r = '{3'd5, 6'b100000};  // 6
      6'd34: r = '{3'd5, 6'b110000};  // 7
      6'd35: r = '{3'd5, 6'b111000};  // 8
      6'd36: r = '{3'd5, 6'b111100};  // 9
      6'd37: r = '{3'd6, 6'b110011};  // comma
      6'd38: r = '{3'd6, 6'b010101};  // period
      6'd39: r = '{3'd6, 6'b001100};  // question mark
      default: r = '{3'd0, 6'b000000};
    endcase
    return r;
  endfunction

endpackage

>>> rtl/morse_led_keyer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_led_keyer_unit
// ascii to international morse encoder, one result item per dot or dash
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                     payload
//  -------   ---------  ---------                     -------
//  command   in         start_i & !busy_o             char_code_i
//  result    out        result_valid_o (one cycle)    led_mask_o, on_units_o,
//                                                     off_units_o, is_dash_o,
//                                                     last_element_o
//  config    in         cfg_valid_i & cfg_ready_o     cfg_index_i, cfg_data_i
//
//  a character with n elements (0 to 6) keeps busy_o high from the
//  accept edge until all its elements are sent; the pattern shift register
//  sends one element per cycle and each result appears in the cycle after
//  its element, and the next character may start as busy_o falls.
//  uncoded bytes leave busy_o low and give no result item.
//  reset clears the control state and loads the register reset values.
//  the receiver cannot stall; config is always ready.
//
module morse_led_keyer_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [7:0]            char_code_i,
  // result
  output logic                  result_valid_o,
  output logic [3:0]            led_mask_o,
  output logic [3:0]            on_units_o,
  output logic [3:0]            off_units_o,
  output logic                  is_dash_o,
  output logic                  last_element_o,
  // config
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  mlk_pkg::cfg_idx_t     cfg_index_i,
  input  mlk_pkg::nib_t         cfg_data_i
);
  import mlk_pkg::*;

  // configuration registers
  nib_t dot_mask_q, dash_mask_q, dot_on_q, dash_on_q, gap_q;

  // element sequencer: pattern shifts out of the top bit, count of elements left
  logic [PatW-1:0] pat_q, pat_d;
  logic [LenW-1:0] cnt_q, cnt_d;

  code_t code;
  logic  accept;
  logic  elem_dash;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = (cnt_q != '0);
  assign accept      = start_i && !busy_o;
  assign code        = code_lookup(table_index(char_code_i));
  assign elem_dash   = pat_q[PatW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_mask_q  <= 4'd1;
      dash_mask_q <= 4'd15;
      dot_on_q    <= 4'd1;
      dash_on_q   <= 4'd2;
      gap_q       <= 4'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegDotLedMask:  dot_mask_q  <= cfg_data_i;
        RegDashLedMask: dash_mask_q <= cfg_data_i;
        RegDotOnUnits:  dot_on_q    <= cfg_data_i;
        RegDashOnUnits: dash_on_q   <= cfg_data_i;
        RegGapUnits:    gap_q       <= cfg_data_i;
        default: ;  // indexes beyond the list are ignored
      endcase
    end
  end

  always_comb begin
    pat_d = pat_q;
    cnt_d = cnt_q;
    if (busy_o) begin
      pat_d = {pat_q[PatW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
    end else if (accept) begin
      pat_d = code.pat;
      cnt_d = code.len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q          <= '0;
      result_valid_o <= 1'b0;
    end else begin
      cnt_q          <= cnt_d;
      result_valid_o <= busy_o;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    pat_q <= pat_d;
    if (busy_o) begin
      led_mask_o     <= elem_dash ? dash_mask_q : dot_mask_q;
      on_units_o     <= elem_dash ? dash_on_q : dot_on_q;
      off_units_o    <= gap_q;
      is_dash_o      <= elem_dash;
      last_element_o <= (cnt_q == LenW'(1));
    end
  end

endmodule
